@@ src/brmq_pkg.sv @@
// ----------------------------------------------------------------------------
// brmq_pkg
// Shared constants, status and operation codes, and the element memory
// request type for the block range-minimum engine.
// ----------------------------------------------------------------------------
package brmq_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int BLOCK_SIZE   = 256;
  localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int OFF_W  = $clog2(BLOCK_SIZE);
  localparam int BLK_W  = ADDR_W - OFF_W;

  localparam int VAL_W = 32;
  localparam int IDX_W = 11;
  localparam int ST_W  = 2;

  // Bound blocks at most this many blocks apart are scanned as one range.
  localparam int NEAR_SPAN = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ src/brmq_if.sv @@
// ----------------------------------------------------------------------------
// brmq_if
// Valid/ready channels for the range-minimum engine: the item channel and
// the result channel.
// ----------------------------------------------------------------------------
interface brmq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [brmq_pkg::VAL_W-1:0]  value;
  logic [brmq_pkg::IDX_W-1:0]  left_index;
  logic [brmq_pkg::IDX_W-1:0]  right_index;

  modport source (output valid, output op, output value, output left_index,
                  output right_index, input ready);
  modport sink (input valid, input op, input value, input left_index,
                input right_index, output ready);
endinterface

interface brmq_out_if;
  logic                        valid;
  logic                        ready;
  logic [brmq_pkg::VAL_W-1:0]  minimum;
  logic [brmq_pkg::ST_W-1:0]   status;

  modport source (output valid, output minimum, output status, input ready);
  modport sink (input valid, input minimum, input status, output ready);
endinterface

@@ src/block_range_minimum_query.sv @@
// ----------------------------------------------------------------------------
// block_range_minimum_query
// Range-minimum engine over an append-only store, using block minima.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on in_ch. A load (op 0) appends value at the next position
//   and folds it into the minimum of that position's block. A query (op 1)
//   returns the minimum of positions left_index..right_index (1-based).
//   Every item produces exactly one result on out_ch. Loads and rejected
//   items return minimum zero; a load into a full store is flagged full and
//   bad query bounds are flagged as a range error.
// Timing:
//   A load or a rejected item passes from transfer through S_FIN into the
//   output register. A query scans its elements in S_SCAN, passes S_DRAIN,
//   folds in the minima of the whole blocks skipped in S_BLKS, and ends in
//   S_FIN. Bound blocks up to two apart are scanned whole, so the longest
//   query spans three full blocks, read one element per cycle.
// Reset:
//   Reset clears the loaded count and the sequencer; the memories are not
//   cleared and need no clearing pass, since only loaded positions are read.
// Stall:
//   A finished result waits in the output register while the receiver
//   stalls; the next item is still accepted and worked on, and its result
//   is held until the output register frees up.
// ----------------------------------------------------------------------------
module block_range_minimum_query (
  input  logic       clk,
  input  logic       rst_n,
  brmq_in_if.sink    in_ch,
  brmq_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_BLKS  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [brmq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [brmq_pkg::ADDR_W-1:0] p_r, p_nxt;
  logic [brmq_pkg::ADDR_W-1:0] end_r, end_nxt;
  logic [brmq_pkg::ADDR_W-1:0] hi_r, hi_nxt;
  logic                        seg2_r, seg2_nxt;
  logic                        blks_r, blks_nxt;
  logic [brmq_pkg::BLK_W-1:0]  blk_r, blk_nxt;
  logic [brmq_pkg::BLK_W-1:0]  blk_last_r, blk_last_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [brmq_pkg::VAL_W-1:0]  acc_r, acc_nxt;
  logic                        acc_first_r, acc_first_nxt;
  logic [brmq_pkg::ST_W-1:0]   st_r, st_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [brmq_pkg::VAL_W-1:0]  out_min_r, out_min_nxt;
  logic [brmq_pkg::ST_W-1:0]   out_st_r, out_st_nxt;

  logic [brmq_pkg::VAL_W-1:0]  bmin_r [brmq_pkg::NUM_BLOCKS];

  brmq_pkg::ram_req_t          ram_req;
  logic [brmq_pkg::VAL_W-1:0]  rd_data;

  logic                        in_fire;
  logic [brmq_pkg::IDX_W-1:0]  lo_full, hi_full;
  logic [brmq_pkg::ADDR_W-1:0] lo, hi, end1;
  logic [brmq_pkg::BLK_W-1:0]  ba, bb, cnt_blk, bm_idx;
  logic [brmq_pkg::BLK_W:0]    span;
  logic                        far, q_bad, ld_full;
  logic                        bm_we;
  logic [brmq_pkg::VAL_W-1:0]  bm_rd, bm_wdata;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign lo_full = in_ch.left_index - brmq_pkg::IDX_W'(1);
  assign hi_full = in_ch.right_index - brmq_pkg::IDX_W'(1);
  assign lo      = lo_full[brmq_pkg::ADDR_W-1:0];
  assign hi      = hi_full[brmq_pkg::ADDR_W-1:0];
  assign ba      = lo[brmq_pkg::ADDR_W-1:brmq_pkg::OFF_W];
  assign bb      = hi[brmq_pkg::ADDR_W-1:brmq_pkg::OFF_W];
  assign span    = {1'b0, bb} - {1'b0, ba};
  assign far     = (span > (brmq_pkg::BLK_W + 1)'(brmq_pkg::NEAR_SPAN));
  assign end1    = far ? {ba, {brmq_pkg::OFF_W{1'b1}}} : hi;

  assign q_bad = (in_ch.left_index == '0) ||
                 (in_ch.left_index > in_ch.right_index) ||
                 (in_ch.right_index > cnt_r);
  assign ld_full = (cnt_r >= brmq_pkg::CNT_W'(brmq_pkg::MAX_ELEMENTS));

  // The block minima share one read address: the load's block while idle,
  // the walking block index otherwise.
  assign cnt_blk = cnt_r[brmq_pkg::ADDR_W-1:brmq_pkg::OFF_W];
  assign bm_idx  = (state_r == S_IDLE) ? cnt_blk : blk_r;
  assign bm_rd   = bmin_r[bm_idx];
  assign bm_wdata = (cnt_r[brmq_pkg::OFF_W-1:0] == '0) ? in_ch.value :
                    ((bm_rd < in_ch.value) ? bm_rd : in_ch.value);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    end_nxt       = end_r;
    hi_nxt        = hi_r;
    seg2_nxt      = seg2_r;
    blks_nxt      = blks_r;
    blk_nxt       = blk_r;
    blk_last_nxt  = blk_last_r;
    rd_vld_nxt    = 1'b0;
    acc_nxt       = acc_r;
    acc_first_nxt = acc_first_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_min_nxt   = out_min_r;
    out_st_nxt    = out_st_r;
    bm_we         = 1'b0;

    ram_req.we    = 1'b0;
    ram_req.waddr = cnt_r[brmq_pkg::ADDR_W-1:0];
    ram_req.wdata = in_ch.value;
    ram_req.raddr = p_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Fold the element read issued in the previous cycle.
    if (rd_vld_r) begin
      acc_first_nxt = 1'b0;
      if (acc_first_r || (rd_data < acc_r)) begin
        acc_nxt = rd_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          acc_nxt       = '0;
          acc_first_nxt = 1'b1;
          st_nxt        = brmq_pkg::ST_OK;
          state_nxt     = S_FIN;
          if (in_ch.op == brmq_pkg::OP_LOAD) begin
            if (ld_full) begin
              st_nxt = brmq_pkg::ST_FULL;
            end else begin
              ram_req.we = 1'b1;
              bm_we      = 1'b1;
              cnt_nxt    = cnt_r + brmq_pkg::CNT_W'(1);
            end
          end else if (q_bad) begin
            st_nxt = brmq_pkg::ST_RANGE;
          end else begin
            p_nxt        = lo;
            end_nxt      = end1;
            hi_nxt       = hi;
            seg2_nxt     = far;
            blks_nxt     = far;
            blk_nxt      = ba + brmq_pkg::BLK_W'(1);
            blk_last_nxt = bb - brmq_pkg::BLK_W'(1);
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (p_r == end_r) begin
          if (seg2_r) begin
            // Jump to the start of the right edge block.
            p_nxt    = {hi_r[brmq_pkg::ADDR_W-1:brmq_pkg::OFF_W],
                        {brmq_pkg::OFF_W{1'b0}}};
            end_nxt  = hi_r;
            seg2_nxt = 1'b0;
          end else begin
            state_nxt = S_DRAIN;
          end
        end else begin
          p_nxt = p_r + brmq_pkg::ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = blks_r ? S_BLKS : S_FIN;
      end
      S_BLKS: begin
        if (bm_rd < acc_r) begin
          acc_nxt = bm_rd;
        end
        if (blk_r == blk_last_r) begin
          state_nxt = S_FIN;
        end else begin
          blk_nxt = blk_r + brmq_pkg::BLK_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = acc_r;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      seg2_r      <= 1'b0;
      blks_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      seg2_r      <= seg2_nxt;
      blks_r      <= blks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    end_r       <= end_nxt;
    hi_r        <= hi_nxt;
    blk_r       <= blk_nxt;
    blk_last_r  <= blk_last_nxt;
    acc_r       <= acc_nxt;
    acc_first_r <= acc_first_nxt;
    st_r        <= st_nxt;
    out_min_r   <= out_min_nxt;
    out_st_r    <= out_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bmin_r[cnt_blk] <= bm_wdata;
    end
  end

  brmq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign out_ch.valid   = out_valid_r;
  assign out_ch.minimum = out_min_r;
  assign out_ch.status  = out_st_r;

endmodule

@@ src/brmq_ram.sv @@
// ----------------------------------------------------------------------------
// brmq_ram
// Element store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module brmq_ram (
  input  logic                       clk,
  input  brmq_pkg::ram_req_t         req,
  output logic [brmq_pkg::VAL_W-1:0] rd_data
);

  logic [brmq_pkg::VAL_W-1:0] mem [brmq_pkg::MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

@@ src/brmq_checker.sv @@
// ----------------------------------------------------------------------------
// brmq_checker
// Port-level checks on the range-minimum engine, bound to the top level.
// ----------------------------------------------------------------------------
module brmq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brmq_pkg::VAL_W-1:0] out_minimum,
  input logic [brmq_pkg::ST_W-1:0]  out_status
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == brmq_pkg::ST_OK) ||
                  (out_status == brmq_pkg::ST_FULL) ||
                  (out_status == brmq_pkg::ST_RANGE))
    else $error("undefined status code");

  // Flagged items carry a zero minimum.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != brmq_pkg::ST_OK) |-> out_minimum == '0)
    else $error("nonzero minimum on flagged result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A result never appears in the cycle after an item transfer.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result offered too early");

endmodule

bind block_range_minimum_query brmq_checker u_brmq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_minimum (out_ch.minimum),
  .out_status  (out_ch.status)
);
